FILE: design/nmsf_pkg.sv
// Shared types, constants and helpers for the neighbor-mean spike filter.
`timescale 1ns / 1ps
`default_nettype none

package nmsf_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int RADIUS    = 3;
   localparam int DEPTH     = 2 * RADIUS;
   localparam int POS_W     = 3;                 // holds 0..DEPTH
   localparam int MAX_RES   = RADIUS + 1;
   localparam int RES_CNT_W = 3;                 // holds 0..MAX_RES
   localparam int MAG_W     = SAMPLE_W + 1;
   localparam int SUM_W     = MAG_W + 1;         // six magnitudes, max 196608
   localparam int THR_W     = 16;
   localparam int CMP_W     = SUM_W + THR_W;
   localparam int MEAN_SHIFT = 21;
   localparam int RECIP_W   = 19;
   localparam int MEAN_PROD_W = SUM_W + RECIP_W;

   // ceil(2^21 / 6): exact floor(sum / 6) for every sum below 2^19
   localparam logic [RECIP_W-1:0] MEAN_RECIP = RECIP_W'(349526);
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [THR_W-1:0] THR_RESET = THR_W'(768);

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = 3;
   localparam int QCNT_W      = 4;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD_ADDR = 2'd0;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                replaced;
      logic                last;
   } nmsf_res_type;

   // results produced by one window step, valid in entries below cnt
   typedef struct packed {
      nmsf_res_type [MAX_RES-1:0] ent;
      logic [RES_CNT_W-1:0]       cnt;
   } nmsf_batch_type;

   function automatic logic [MAG_W-1:0] sample_mag(input logic [SAMPLE_W-1:0] v);
      logic [MAG_W-1:0] ext;
      ext = {v[SAMPLE_W-1], v};
      return v[SAMPLE_W-1] ? MAG_W'(~ext + MAG_W'(1)) : ext;
   endfunction

endpackage

`default_nettype wire

FILE: design/nmsf_window.sv
// Sample window, spike test and per-step result batch.
`timescale 1ns / 1ps
`default_nettype none

module nmsf_window (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          step,
   input  wire logic [nmsf_pkg::SAMPLE_W-1:0] sample,
   input  wire logic                          frame_end,
   input  wire logic [nmsf_pkg::THR_W-1:0]    threshold,
   output nmsf_pkg::nmsf_batch_type           batch
);
   import nmsf_pkg::*;

   logic [SAMPLE_W-1:0] win_ff [DEPTH];
   logic [SAMPLE_W-1:0] win_in [DEPTH];
   logic [POS_W-1:0]    pos_ff, pos_in;

   logic                full, has_head;
   logic [SUM_W-1:0]    nsum;
   logic [MAG_W-1:0]    cmag;
   logic [CMP_W-1:0]    lhs, rhs;
   logic [MEAN_PROD_W-1:0] mean_prod;
   logic [SAMPLE_W-1:0] mean_raw, mean_sat;
   logic                spike;
   logic [RES_CNT_W-1:0] tail_cnt;

   assign full     = (pos_ff >= POS_W'(DEPTH));
   assign has_head = (pos_ff >= POS_W'(RADIUS));

   always_comb begin
      nsum = SUM_W'(sample_mag(sample));
      for (int i = 0; i < DEPTH; i++) begin
         if (i != RADIUS) nsum = nsum + SUM_W'(sample_mag(win_ff[i]));
      end
   end

   assign cmag = sample_mag(win_ff[RADIUS]);
   // |c| * 6 * 256 against sum * threshold
   assign lhs  = CMP_W'({cmag, 10'b0}) + CMP_W'({cmag, 9'b0});
   assign rhs  = CMP_W'(nsum) * CMP_W'(threshold);
   assign spike = full && (lhs > rhs);

   assign mean_prod = MEAN_PROD_W'(nsum) * MEAN_PROD_W'(MEAN_RECIP);
   assign mean_raw  = mean_prod[MEAN_SHIFT +: SAMPLE_W];
   assign mean_sat  = (mean_raw > SAMPLE_MAX) ? SAMPLE_MAX : mean_raw;

   // shifted window; the replaced center becomes a left neighbor
   always_comb begin
      for (int i = 0; i < DEPTH - 1; i++) begin
         win_in[i] = win_ff[i + 1];
      end
      if (spike) win_in[RADIUS - 1] = mean_sat;
      win_in[DEPTH - 1] = sample;
   end

   always_comb begin
      if (!frame_end)
         tail_cnt = '0;
      else if (pos_ff < POS_W'(RADIUS))
         tail_cnt = RES_CNT_W'(pos_ff) + RES_CNT_W'(1);
      else
         tail_cnt = RES_CNT_W'(RADIUS);
   end

   always_comb begin
      logic [RES_CNT_W-1:0] j;
      logic [POS_W-1:0]     idx;
      batch.cnt = RES_CNT_W'(has_head) + tail_cnt;
      for (int k = 0; k < MAX_RES; k++) begin
         j   = RES_CNT_W'(k) - RES_CNT_W'(has_head);
         idx = POS_W'(DEPTH) - POS_W'(tail_cnt) + POS_W'(j);
         batch.ent[k].sample   = win_in[idx];
         batch.ent[k].replaced = 1'b0;
         batch.ent[k].last     = (j == tail_cnt - RES_CNT_W'(1));
         if (k == 0 && has_head) begin
            batch.ent[k].sample   = spike ? mean_sat : win_ff[RADIUS];
            batch.ent[k].replaced = spike;
            batch.ent[k].last     = 1'b0;
         end
      end
   end

   always_comb begin
      if (frame_end)
         pos_in = '0;
      else if (!full)
         pos_in = pos_ff + POS_W'(1);
      else
         pos_in = pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (step) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         win_ff <= win_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/nmsf_out_queue.sv
// Result queue: takes up to four words per cycle, hands out one while out_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module nmsf_out_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire nmsf_pkg::nmsf_batch_type  batch,
   output logic                           room,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output nmsf_pkg::nmsf_res_type         out_word
);
   import nmsf_pkg::*;

   nmsf_res_type       mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic [RES_CNT_W-1:0] push_n;
   logic               pop;

   assign push_n    = push ? batch.cnt : '0;
   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_word  = mem[rd_ptr_ff];
   assign room      = (count_ff <= QCNT_W'(QUEUE_DEPTH - MAX_RES));

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + QCNT_W'(push_n) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < MAX_RES; k++) begin
         if (RES_CNT_W'(k) < push_n) mem[wr_ptr_ff + QPTR_W'(k)] <= batch.ent[k];
      end
   end

endmodule

`default_nettype wire

FILE: design/neighbor_mean_spike_filter.sv
// A word enters the result queue when the word three samples later in its frame
//   steps the window; at frame end the held samples follow one per cycle while rsp_tready is high.
// Throughput: one sample per cycle while the queue has room; the window update is combinational.
// Frame end writes up to four words into an 8-deep result queue; input stalls
//   only while that queue holds more than four words.
// Reset (synchronous): clears frame position and queue, threshold back to 3.0.
`timescale 1ns / 1ps
`default_nettype none

module neighbor_mean_spike_filter (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [nmsf_pkg::SAMPLE_W-1:0]   req_tdata,   // [15:0] sample_in
   input  wire logic                            req_tlast,   // frame_end
   // result stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [nmsf_pkg::SAMPLE_W-1:0]        rsp_tdata,   // [15:0] sample_out
   output logic                                 rsp_tuser,   // [0] was_replaced
   output logic                                 rsp_tlast,   // out_last
   // register port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [nmsf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [nmsf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [nmsf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import nmsf_pkg::*;

   logic [THR_W-1:0]    thr_ff;
   logic                in_valid_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;
   logic                in_last_ff;
   logic                step, room;
   nmsf_batch_type      batch;
   nmsf_res_type        out_word;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_THRESHOLD_ADDR) ?
                       CSR_DATA_W'(thr_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == CSR_THRESHOLD_ADDR) begin
         thr_ff <= csr_pwdata[THR_W-1:0];
      end
   end

   // input word register; step runs when the queue can take a full batch
   assign step       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_sample_ff <= req_tdata;
         in_last_ff   <= req_tlast;
      end
   end

   nmsf_window u_window (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .sample    (in_sample_ff),
      .frame_end (in_last_ff),
      .threshold (thr_ff),
      .batch     (batch)
   );

   nmsf_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step),
      .batch     (batch),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (out_word)
   );

   assign rsp_tdata = out_word.sample;
   assign rsp_tuser = out_word.replaced;
   assign rsp_tlast = out_word.last;

endmodule

`default_nettype wire

FILE: design/nmsf_checker.sv
// Port-level checks for the spike filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module nmsf_port_checks (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [nmsf_pkg::SAMPLE_W-1:0]   rsp_tdata,
   input wire logic                            rsp_tuser,
   input wire logic                            rsp_tlast,
   input wire logic                            req_tready,
   input wire logic                            csr_psel,
   input wire logic                            csr_penable,
   input wire logic                            csr_pwrite,
   input wire logic [nmsf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [nmsf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input wire logic [nmsf_pkg::CSR_DATA_W-1:0] csr_prdata,
   input wire logic                            csr_pready
);
   import nmsf_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // out of reset: nothing queued, input open
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

   // a replaced sample is the mean: never negative, never the frame's last word
   a_replaced: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast && !rsp_tdata[SAMPLE_W-1])
      else $error("replaced word is negative or marks frame end");

   // threshold reads back what was written
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready &&
      csr_paddr == CSR_THRESHOLD_ADDR |=>
         csr_paddr != CSR_THRESHOLD_ADDR ||
         csr_prdata == CSR_DATA_W'($past(csr_pwdata[THR_W-1:0])))
      else $error("threshold readback mismatch");

endmodule

bind neighbor_mean_spike_filter nmsf_port_checks u_nmsf_checker (.*);

`default_nettype wire
